// ===== design/circle_overlap_resolver_defines.svh =====
// Assertion macros shared by the circle overlap resolver modules.
// No dependencies; each using module must have clk and rst in scope.
`ifndef CIRCLE_OVERLAP_RESOLVER_DEFINES_SVH
`define CIRCLE_OVERLAP_RESOLVER_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define COR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define COR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/cor_pkg.sv =====
// Shared widths, command codes, item types and saturation for the resolver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cor_pkg;

  localparam int CoordW  = 16;  // Q11.4 centre
  localparam int RadW    = 12;  // Q8.4 radius / width
  localparam int AbsW    = 16;  // |first - second|
  localparam int MagW    = 13;  // |d| when the circles overlap
  localparam int D2W     = 27;  // squared distance when overlapping
  localparam int SumW    = 14;  // radius sum in Q.5
  localparam int SqW     = 44;  // radicand / root working width
  localparam int RootW   = 22;  // root digits
  localparam int DistW   = 21;  // distance in Q.12 when overlapping
  localparam int OvW     = 21;  // overlap in Q.12
  localparam int DenW    = 23;  // dist * f
  localparam int NumW    = 34;  // |d| * overlap
  localparam int DivNW   = 36;  // 2*num + den
  localparam int DivDW   = 24;  // 2*den
  localparam int DivCmpW = 37;
  localparam int QuotW   = 14;
  localparam int PosSumW = 18;

  localparam logic CMD_MUTUAL = 1'b0;
  localparam logic CMD_STATIC = 1'b1;

  // distance used when centres coincide: direction (+1, 0)
  localparam logic [DistW-1:0] UNIT_DIST = DistW'(256);

  localparam int DEF_MID_DEPTH = 8;
  localparam int DEF_OUT_DEPTH = 64;

  typedef struct packed {
    logic                     cmd;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    logic                     neg_x;
    logic                     neg_y;
    logic [MagW-1:0]          mag_x;
    logic [MagW-1:0]          mag_y;
    logic [D2W-1:0]           d2;
    logic [SumW-1:0]          s5;
    logic                     hit;
    logic                     zero;
  } mid_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    logic                     hit;
  } res_item_t;

  function automatic logic signed [CoordW-1:0] sat_coord(
    input logic signed [PosSumW-1:0] v
  );
    logic signed [CoordW-1:0] r;
    priority if (v[PosSumW-1:CoordW-1] == '0 || v[PosSumW-1:CoordW-1] == '1) begin
      r = v[CoordW-1:0];
    end else if (v[PosSumW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/circle_overlap_resolver.sv =====
// Circle overlap resolver. Takes one circle pair per cycle while full is low
// on a push/full queue port and returns one result per pair, in order, on an empty/pop port.
// Path: two front stages and the hand-off queue, then
// the back end's 22-stage square root, three stages for overlap, products and
// rounding, a 14-stage divider per axis and the apply/saturate stage, then the
// result memory write and its read register. Sustained rate is one item per
// cycle while results are popped; it is set by the result memory depth, which must cover the back end's
// in-flight items, since issue into the back end waits for a free reserved slot.
`timescale 1ns / 1ps
`default_nettype none

module circle_overlap_resolver import cor_pkg::*; #(
  parameter int MID_DEPTH = DEF_MID_DEPTH,
  parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  output logic                    full,
  input  wire                     command,
  input  wire signed [CoordW-1:0] first_x,
  input  wire signed [CoordW-1:0] first_y,
  input  wire        [RadW-1:0]   first_radius,
  input  wire signed [CoordW-1:0] second_x,
  input  wire signed [CoordW-1:0] second_y,
  input  wire        [RadW-1:0]   second_extent,
  output logic                    empty,
  input  wire                     pop,
  output logic signed [CoordW-1:0] new_first_x,
  output logic signed [CoordW-1:0] new_first_y,
  output logic signed [CoordW-1:0] new_second_x,
  output logic signed [CoordW-1:0] new_second_y,
  output logic                    overlapped
);

  logic      q_valid, credit_ok, take, res_valid;
  mid_item_t q_item;
  res_item_t res_item, rd_item;

  assign take = q_valid && credit_ok;

  cor_front #(.MID_DEPTH(MID_DEPTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .first_x       (first_x),
    .first_y       (first_y),
    .first_radius  (first_radius),
    .second_x      (second_x),
    .second_y      (second_y),
    .second_extent (second_extent),
    .q_valid       (q_valid),
    .q_take        (take),
    .q_item        (q_item)
  );

  cor_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .in_item   (q_item),
    .out_valid (res_valid),
    .out_item  (res_item)
  );

  cor_out_queue #(.OUT_DEPTH(OUT_DEPTH)) u_outq (
    .clk       (clk),
    .rst       (rst),
    .issue     (take),
    .credit_ok (credit_ok),
    .wr_en     (res_valid),
    .wr_item   (res_item),
    .pop       (pop),
    .empty     (empty),
    .rd_item   (rd_item)
  );

  assign new_first_x  = rd_item.x1;
  assign new_first_y  = rd_item.y1;
  assign new_second_x = rd_item.x2;
  assign new_second_y = rd_item.y2;
  assign overlapped   = rd_item.hit;

endmodule

`default_nettype wire

// ===== design/cor_front.sv =====
// Front end: takes items, forms differences, squares and the overlap test,
// and holds classified items in a short queue. Depends on cor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cor_front import cor_pkg::*; #(
  parameter int MID_DEPTH = DEF_MID_DEPTH
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  output logic                    full,
  input  wire                     command,
  input  wire signed [CoordW-1:0] first_x,
  input  wire signed [CoordW-1:0] first_y,
  input  wire        [RadW-1:0]   first_radius,
  input  wire signed [CoordW-1:0] second_x,
  input  wire signed [CoordW-1:0] second_y,
  input  wire        [RadW-1:0]   second_extent,
  output logic                    q_valid,
  input  wire                     q_take,
  output mid_item_t               q_item
);

  `include "circle_overlap_resolver_defines.svh"

  localparam int PtrW = $clog2(MID_DEPTH);
  localparam int CntW = $clog2(MID_DEPTH + 1);

  logic accept;
  logic [CntW-1:0] qres, qres_next;   // items taken in and not yet handed on

  assign full   = (qres == CntW'(MID_DEPTH));
  assign accept = push && !full;

  // stage 1: differences and radius sum
  logic [AbsW:0] dx_u, dy_u, adx_w, ady_w;
  logic [SumW-1:0] s5_w;
  logic [SumW-2:0] rsum;

  always_comb begin
    dx_u  = {first_x[CoordW-1], first_x} - {second_x[CoordW-1], second_x};
    dy_u  = {first_y[CoordW-1], first_y} - {second_y[CoordW-1], second_y};
    adx_w = dx_u[AbsW] ? (~dx_u + (AbsW+1)'(1)) : dx_u;
    ady_w = dy_u[AbsW] ? (~dy_u + (AbsW+1)'(1)) : dy_u;
    rsum  = (SumW-1)'(first_radius) + (SumW-1)'(second_extent);
    if (command == CMD_STATIC) begin
      s5_w = {1'b0, first_radius, 1'b0} + SumW'(second_extent);
    end else begin
      s5_w = {rsum, 1'b0};
    end
  end

  logic v1;
  logic s1_cmd, s1_negx, s1_negy;
  logic signed [CoordW-1:0] s1_x1, s1_y1, s1_x2, s1_y2;
  logic [AbsW-1:0] s1_adx, s1_ady;
  logic [SumW-1:0] s1_s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    s1_cmd  <= command;
    s1_x1   <= first_x;
    s1_y1   <= first_y;
    s1_x2   <= second_x;
    s1_y2   <= second_y;
    s1_negx <= dx_u[AbsW];
    s1_negy <= dy_u[AbsW];
    s1_adx  <= adx_w[AbsW-1:0];
    s1_ady  <= ady_w[AbsW-1:0];
    s1_s5   <= s5_w;
  end

  // stage 2: squares
  logic v2;
  logic s2_cmd, s2_negx, s2_negy;
  logic signed [CoordW-1:0] s2_x1, s2_y1, s2_x2, s2_y2;
  logic [AbsW-1:0] s2_adx, s2_ady;
  logic [SumW-1:0] s2_s5;
  logic [2*AbsW-1:0] s2_sqx, s2_sqy;
  logic [2*SumW-1:0] s2_s5sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_cmd  <= s1_cmd;
    s2_x1   <= s1_x1;
    s2_y1   <= s1_y1;
    s2_x2   <= s1_x2;
    s2_y2   <= s1_y2;
    s2_negx <= s1_negx;
    s2_negy <= s1_negy;
    s2_adx  <= s1_adx;
    s2_ady  <= s1_ady;
    s2_s5   <= s1_s5;
    s2_sqx  <= s1_adx * s1_adx;
    s2_sqy  <= s1_ady * s1_ady;
    s2_s5sq <= s1_s5 * s1_s5;
  end

  // classify: exact overlap test 4*d2 < s5^2
  logic [2*AbsW:0] d2_w;
  logic hit_w;
  mid_item_t w_item;

  always_comb begin
    d2_w  = (2*AbsW+1)'(s2_sqx) + (2*AbsW+1)'(s2_sqy);
    hit_w = {d2_w, 2'b00} < (2*AbsW+3)'(s2_s5sq);
    w_item.cmd   = s2_cmd;
    w_item.x1    = s2_x1;
    w_item.y1    = s2_y1;
    w_item.x2    = s2_x2;
    w_item.y2    = s2_y2;
    w_item.neg_x = s2_negx;
    w_item.neg_y = s2_negy;
    w_item.hit   = hit_w;
    w_item.zero  = (d2_w == '0);
    if (!hit_w) begin
      w_item.mag_x = '0;
      w_item.mag_y = '0;
      w_item.d2    = '0;
      w_item.s5    = '0;
    end else if (d2_w == '0) begin
      w_item.mag_x = MagW'(1);
      w_item.mag_y = '0;
      w_item.d2    = '0;
      w_item.s5    = s2_s5;
    end else begin
      w_item.mag_x = s2_adx[MagW-1:0];
      w_item.mag_y = s2_ady[MagW-1:0];
      w_item.d2    = d2_w[D2W-1:0];
      w_item.s5    = s2_s5;
    end
  end

  // item queue toward the back end
  mid_item_t qmem [MID_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt;
  logic take;

  assign q_valid = (cnt != '0);
  assign take    = q_take && q_valid;
  assign q_item  = qmem[rd_ptr];

  always_comb begin
    qres_next = qres;
    if (accept) begin
      qres_next = qres_next + CntW'(1);
    end
    if (take) begin
      qres_next = qres_next - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      qmem[wr_ptr] <= w_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
      qres   <= '0;
    end else begin
      qres <= qres_next;
      if (v2) begin
        wr_ptr <= (wr_ptr == PtrW'(MID_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PtrW'(MID_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (v2 && !take) begin
        cnt <= cnt + CntW'(1);
      end else if (!v2 && take) begin
        cnt <= cnt - CntW'(1);
      end
    end
  end

  `COR_ASSERT_IMPLY(a_queue_room, v2, cnt < CntW'(MID_DEPTH), "front queue overflow")
  `COR_ASSERT_ALWAYS(a_reserve_match,
    (CntW+1)'(qres) == (CntW+1)'(cnt) + (CntW+1)'(v1) + (CntW+1)'(v2),
    "front reservation count out of step")

endmodule

`default_nettype wire

// ===== design/cor_back.sv =====
// Back end: pipelined square root, overlap, per-axis scaled move by a
// pipelined divider, then apply and saturate. Depends on cor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cor_back import cor_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  input  mid_item_t in_item,
  output logic      out_valid,
  output res_item_t out_item
);

  `include "circle_overlap_resolver_defines.svh"

  // square root, one root digit per stage
  logic            sq_v   [RootW];
  logic [SqW-1:0]  sq_rem [RootW];
  logic [SqW-1:0]  sq_res [RootW];
  mid_item_t       sq_it  [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_sq
    localparam logic [SqW-1:0] Bit = {{(SqW-1){1'b0}}, 1'b1} << (2*(RootW-1-s));
    logic           v_i;
    logic [SqW-1:0] rem_i, res_i, trial, rem_n, res_n;
    mid_item_t      it_i;

    if (s == 0) begin : g_in
      assign v_i   = in_valid;
      assign rem_i = SqW'({in_item.d2, 16'b0});
      assign res_i = '0;
      assign it_i  = in_item;
    end else begin : g_link
      assign v_i   = sq_v[s-1];
      assign rem_i = sq_rem[s-1];
      assign res_i = sq_res[s-1];
      assign it_i  = sq_it[s-1];
    end

    always_comb begin
      trial = res_i + Bit;
      if (rem_i >= trial) begin
        rem_n = rem_i - trial;
        res_n = (res_i >> 1) + Bit;
      end else begin
        rem_n = rem_i;
        res_n = res_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[s] <= 1'b0;
      end else begin
        sq_v[s] <= v_i;
      end
      sq_rem[s] <= rem_n;
      sq_res[s] <= res_n;
      sq_it[s]  <= it_i;
    end
  end

  // overlap and divisor
  logic [DistW-1:0] root, dist_eff;
  mid_item_t sq_last;
  assign sq_last  = sq_it[RootW-1];
  assign root     = sq_res[RootW-1][DistW-1:0];
  assign dist_eff = sq_last.zero ? UNIT_DIST : root;

  logic            ov_v;
  logic [OvW-1:0]  ov_ov;
  logic [DenW-1:0] ov_den;
  mid_item_t       ov_it;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov_v <= 1'b0;
    end else begin
      ov_v <= sq_v[RootW-1];
    end
    ov_ov  <= {sq_last.s5, 7'b0} - root;
    ov_den <= (sq_last.cmd == CMD_STATIC) ? {2'b00, dist_eff} : {1'b0, dist_eff, 1'b0};
    ov_it  <= sq_last;
  end

  // products
  logic            mu_v;
  logic [NumW-1:0] mu_nx, mu_ny;
  logic [DenW-1:0] mu_den;
  mid_item_t       mu_it;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_v <= 1'b0;
    end else begin
      mu_v <= ov_v;
    end
    mu_nx  <= NumW'(ov_it.mag_x) * NumW'(ov_ov);
    mu_ny  <= NumW'(ov_it.mag_y) * NumW'(ov_ov);
    mu_den <= ov_den;
    mu_it  <= ov_it;
  end

  // rounding folded in: q = (2*num + den) / (2*den)
  logic             pr_v;
  logic [DivNW-1:0] pr_nx, pr_ny;
  logic [DivDW-1:0] pr_d;
  mid_item_t        pr_it;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_v <= 1'b0;
    end else begin
      pr_v <= mu_v;
    end
    pr_nx <= DivNW'({mu_nx, 1'b0}) + DivNW'(mu_den);
    pr_ny <= DivNW'({mu_ny, 1'b0}) + DivNW'(mu_den);
    pr_d  <= {mu_den, 1'b0};
    pr_it <= mu_it;
  end

  // restoring divider, one quotient bit per stage, both axes side by side
  logic             dv_v  [QuotW];
  logic [DivNW-1:0] dv_rx [QuotW];
  logic [DivNW-1:0] dv_ry [QuotW];
  logic [QuotW-1:0] dv_qx [QuotW];
  logic [QuotW-1:0] dv_qy [QuotW];
  logic [DivDW-1:0] dv_d  [QuotW];
  mid_item_t        dv_it [QuotW];

  for (genvar i = 0; i < QuotW; i++) begin : g_div
    localparam int Sh = QuotW - 1 - i;
    logic               v_i, gex, gey;
    logic [DivNW-1:0]   rx_i, ry_i;
    logic [QuotW-1:0]   qx_i, qy_i;
    logic [DivDW-1:0]   d_i;
    logic [DivCmpW-1:0] dsh;
    mid_item_t          it_i;

    if (i == 0) begin : g_in
      assign v_i  = pr_v;
      assign rx_i = pr_nx;
      assign ry_i = pr_ny;
      assign qx_i = '0;
      assign qy_i = '0;
      assign d_i  = pr_d;
      assign it_i = pr_it;
    end else begin : g_link
      assign v_i  = dv_v[i-1];
      assign rx_i = dv_rx[i-1];
      assign ry_i = dv_ry[i-1];
      assign qx_i = dv_qx[i-1];
      assign qy_i = dv_qy[i-1];
      assign d_i  = dv_d[i-1];
      assign it_i = dv_it[i-1];
    end

    assign dsh = DivCmpW'(d_i) << Sh;
    assign gex = DivCmpW'(rx_i) >= dsh;
    assign gey = DivCmpW'(ry_i) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i] <= 1'b0;
      end else begin
        dv_v[i] <= v_i;
      end
      dv_rx[i] <= gex ? DivNW'(DivCmpW'(rx_i) - dsh) : rx_i;
      dv_ry[i] <= gey ? DivNW'(DivCmpW'(ry_i) - dsh) : ry_i;
      dv_qx[i] <= {qx_i[QuotW-2:0], gex};
      dv_qy[i] <= {qy_i[QuotW-2:0], gey};
      dv_d[i]  <= d_i;
      dv_it[i] <= it_i;
    end
  end

  // apply the move and saturate
  mid_item_t fin;
  logic signed [PosSumW-1:0] mvx, mvy, sx1, sy1, sx2, sy2;

  assign fin = dv_it[QuotW-1];

  always_comb begin
    mvx = PosSumW'(dv_qx[QuotW-1]);
    mvy = PosSumW'(dv_qy[QuotW-1]);
    if (fin.neg_x) begin
      mvx = -mvx;
    end
    if (fin.neg_y) begin
      mvy = -mvy;
    end
    if (!fin.hit) begin
      mvx = '0;
      mvy = '0;
    end
    sx1 = PosSumW'(fin.x1) + mvx;
    sy1 = PosSumW'(fin.y1) + mvy;
    if (fin.cmd == CMD_STATIC) begin
      sx2 = PosSumW'(fin.x2);
      sy2 = PosSumW'(fin.y2);
    end else begin
      sx2 = PosSumW'(fin.x2) - mvx;
      sy2 = PosSumW'(fin.y2) - mvy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_v[QuotW-1];
    end
    out_item.x1  <= sat_coord(sx1);
    out_item.y1  <= sat_coord(sy1);
    out_item.x2  <= sat_coord(sx2);
    out_item.y2  <= sat_coord(sy2);
    out_item.hit <= fin.hit;
  end

  // an overlapping pair always has distance below the radius sum
  `COR_ASSERT_IMPLY(a_overlap_positive, sq_v[RootW-1] && sq_last.hit,
    sq_res[RootW-1] < SqW'({sq_last.s5, 7'b0}), "overlap not positive")
  `COR_ASSERT_IMPLY(a_div_remainder, dv_v[QuotW-1] && fin.hit,
    dv_rx[QuotW-1] < DivNW'(dv_d[QuotW-1]) && dv_ry[QuotW-1] < DivNW'(dv_d[QuotW-1]),
    "divider remainder not below divisor")

endmodule

`default_nettype wire

// ===== design/cor_out_queue.sv =====
// Result queue: memory with a registered read into the output register,
// plus the slot reservation that gates issue into the back end. Uses cor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cor_out_queue import cor_pkg::*; #(
  parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       issue,
  output logic      credit_ok,
  input  wire       wr_en,
  input  res_item_t wr_item,
  input  wire       pop,
  output logic      empty,
  output res_item_t rd_item
);

  `include "circle_overlap_resolver_defines.svh"

  localparam int PtrW = $clog2(OUT_DEPTH);
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  res_item_t mem [OUT_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt, reserved;
  logic out_valid, pop_fire, load;

  assign empty     = !out_valid;
  assign pop_fire  = pop && out_valid;
  assign load      = (cnt != '0) && (!out_valid || pop_fire);
  assign credit_ok = (reserved < CntW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
    if (load) begin
      rd_item <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      cnt       <= '0;
      reserved  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (load) begin
        rd_ptr <= (rd_ptr == PtrW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (wr_en && !load) begin
        cnt <= cnt + CntW'(1);
      end else if (!wr_en && load) begin
        cnt <= cnt - CntW'(1);
      end
      if (issue && !pop_fire) begin
        reserved <= reserved + CntW'(1);
      end else if (!issue && pop_fire) begin
        reserved <= reserved - CntW'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  `COR_ASSERT_IMPLY(a_mem_room, wr_en && !load, cnt < CntW'(OUT_DEPTH),
    "result memory overflow")
  `COR_ASSERT_ALWAYS(a_reserve_cover,
    (CntW+1)'(cnt) + (CntW+1)'(out_valid) <= (CntW+1)'(reserved),
    "result held without a reserved slot")

endmodule

`default_nettype wire
